// ----- rtl/fdpc_pkg.sv -----
// Shared types, constants and register map of the feathered disc pixel compositor.
package fdpc_pkg;

    localparam int DEF_PANEL_WIDTH  = 220;
    localparam int DEF_PANEL_HEIGHT = 176;

    localparam int GEOM_STAGES  = 4;
    localparam int DIV_STAGES   = 8;
    localparam int BLEND_STAGES = 2;
    localparam int PIPE_LATENCY = GEOM_STAGES + DIV_STAGES + BLEND_STAGES;

    typedef enum logic [1:0] {
        MODE_RENDER = 2'd0,
        MODE_WR_BG  = 2'd1,
        MODE_WR_ART = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        REGION_BG  = 2'd0,
        REGION_ART = 2'd1,
        REGION_MIX = 2'd2
    } region_t;

    localparam logic [2:0] CFG_DISC_CX = 3'd0;
    localparam logic [2:0] CFG_DISC_CY = 3'd1;
    localparam logic [2:0] CFG_REST_CX = 3'd2;
    localparam logic [2:0] CFG_REST_CY = 3'd3;
    localparam logic [2:0] CFG_INNER   = 3'd4;
    localparam logic [2:0] CFG_OUTER   = 3'd5;

    typedef struct packed {
        logic [7:0]  disc_cx;
        logic [7:0]  disc_cy;
        logic [7:0]  rest_cx;
        logic [7:0]  rest_cy;
        logic [15:0] inner;
        logic [15:0] outer;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        disc_cx: 8'd106,
        disc_cy: 8'd82,
        rest_cx: 8'd106,
        rest_cy: 8'd82,
        inner:   16'd2500,
        outer:   16'd3844
    };

    // Classification of one render transaction leaving the geometry stages
    typedef struct packed {
        logic        valid;
        region_t     region;
        logic [15:0] num;
        logic [15:0] den;
    } geom_res_t;

    // Pixel payload that travels beside the divider
    typedef struct packed {
        region_t     region;
        logic [15:0] art;
        logic [15:0] bg;
    } pix_data_t;

endpackage

// ----- rtl/fdpc_geom.sv -----
// Geometry stages: clamping, distance, store addresses and region classification.
module fdpc_geom
    import fdpc_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [1:0]    mode,
    input  logic [7:0]    pos_x,
    input  logic [7:0]    pos_y,
    input  logic [15:0]   write_pixel,
    input  cfg_t          cfg,
    output logic          wr_bg,
    output logic          wr_art,
    output logic [AW-1:0] bg_addr,
    output logic [AW-1:0] art_addr,
    output logic [15:0]   wr_data,
    output geom_res_t     res
);

    localparam int XW = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int YW = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;

    // stage 1
    logic [7:0]        cx8, cy8;
    logic              inpanel;
    logic signed [9:0] dx, dy;

    logic              v1_reg;
    logic [1:0]        mode1_reg;
    logic              inpanel1_reg;
    logic [15:0]       wpix1_reg;
    logic [XW-1:0]     px1_reg;
    logic [YW-1:0]     py1_reg;
    logic signed [9:0] dx1_reg, dy1_reg;

    always_comb
    begin
        cx8 = (32'(pos_x) > PANEL_WIDTH - 1) ? 8'(PANEL_WIDTH - 1) : pos_x;
        cy8 = (32'(pos_y) > PANEL_HEIGHT - 1) ? 8'(PANEL_HEIGHT - 1) : pos_y;
        inpanel = (32'(pos_x) < PANEL_WIDTH) && (32'(pos_y) < PANEL_HEIGHT);
        dx = $signed({2'b00, cx8}) - $signed({2'b00, cfg.disc_cx});
        dy = $signed({2'b00, cy8}) - $signed({2'b00, cfg.disc_cy});
    end

    // stage 2
    logic signed [19:0] dx_sq, dy_sq;
    logic signed [11:0] sx_full, sy_full;
    logic [XW-1:0]      sx_cl;
    logic [YW-1:0]      sy_cl;

    logic               v2_reg;
    logic [1:0]         mode2_reg;
    logic               inpanel2_reg;
    logic [15:0]        wpix2_reg;
    logic [15:0]        dxsq2_reg, dysq2_reg;
    logic [AW-1:0]      bg_row2_reg, art_row2_reg;
    logic [XW-1:0]      px2_reg, sx2_reg;

    always_comb
    begin
        dx_sq   = dx1_reg * dx1_reg;
        dy_sq   = dy1_reg * dy1_reg;
        sx_full = $signed({4'b0000, cfg.rest_cx}) + 12'(dx1_reg);
        sy_full = $signed({4'b0000, cfg.rest_cy}) + 12'(dy1_reg);
        if (sx_full < 0)
            sx_cl = '0;
        else if (int'(sx_full) > PANEL_WIDTH - 1)
            sx_cl = XW'(PANEL_WIDTH - 1);
        else
            sx_cl = XW'(sx_full);
        if (sy_full < 0)
            sy_cl = '0;
        else if (int'(sy_full) > PANEL_HEIGHT - 1)
            sy_cl = YW'(PANEL_HEIGHT - 1);
        else
            sy_cl = YW'(sy_full);
    end

    // stage 3
    logic          v3_reg;
    logic [1:0]    mode3_reg;
    logic          inpanel3_reg;
    logic [15:0]   wpix3_reg;
    logic [16:0]   d2_3_reg;
    logic [AW-1:0] bg_addr3_reg, art_addr3_reg;

    // stage 4
    geom_res_t res_next, res_reg;

    always_comb
    begin
        res_next.valid = v3_reg && (mode3_reg == MODE_RENDER);
        if (d2_3_reg >= 17'(cfg.outer))
            res_next.region = REGION_BG;
        else if (d2_3_reg <= 17'(cfg.inner))
            res_next.region = REGION_ART;
        else
            res_next.region = REGION_MIX;
        res_next.num = 16'(d2_3_reg - 17'(cfg.inner));
        res_next.den = cfg.outer - cfg.inner;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            res_reg <= '0;
        end
        else
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg    <= mode;
        inpanel1_reg <= inpanel;
        wpix1_reg    <= write_pixel;
        px1_reg      <= XW'(cx8);
        py1_reg      <= YW'(cy8);
        dx1_reg      <= dx;
        dy1_reg      <= dy;

        mode2_reg    <= mode1_reg;
        inpanel2_reg <= inpanel1_reg;
        wpix2_reg    <= wpix1_reg;
        dxsq2_reg    <= dx_sq[15:0];
        dysq2_reg    <= dy_sq[15:0];
        bg_row2_reg  <= AW'(py1_reg * PANEL_WIDTH);
        art_row2_reg <= AW'(sy_cl * PANEL_WIDTH);
        px2_reg      <= px1_reg;
        sx2_reg      <= sx_cl;

        mode3_reg     <= mode2_reg;
        inpanel3_reg  <= inpanel2_reg;
        wpix3_reg     <= wpix2_reg;
        d2_3_reg      <= 17'(dxsq2_reg) + 17'(dysq2_reg);
        bg_addr3_reg  <= bg_row2_reg + AW'(px2_reg);
        art_addr3_reg <= art_row2_reg + AW'(sx2_reg);
    end

    assign wr_bg    = v3_reg && (mode3_reg == MODE_WR_BG) && inpanel3_reg;
    assign wr_art   = v3_reg && (mode3_reg == MODE_WR_ART) && inpanel3_reg;
    assign bg_addr  = bg_addr3_reg;
    assign art_addr = art_addr3_reg;
    assign wr_data  = wpix3_reg;
    assign res      = res_reg;

endmodule

// ----- rtl/fdpc_store.sv -----
// Background and artwork frame stores, one write and one registered read each.
module fdpc_store
    import fdpc_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT,
    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_bg,
    input  logic          wr_art,
    input  logic [AW-1:0] bg_addr,
    input  logic [AW-1:0] art_addr,
    input  logic [15:0]   wr_data,
    output logic [15:0]   bg_pixel,
    output logic [15:0]   art_pixel
);

    logic [15:0] bg_mem  [DEPTH];
    logic [15:0] art_mem [DEPTH];
    logic [15:0] bg_rd_reg, art_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_bg)
            bg_mem[bg_addr] <= wr_data;
        bg_rd_reg <= bg_mem[bg_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_art)
            art_mem[bg_addr] <= wr_data;
        art_rd_reg <= art_mem[art_addr];
    end

    assign bg_pixel  = bg_rd_reg;
    assign art_pixel = art_rd_reg;

endmodule

// ----- rtl/fdpc_div.sv -----
// Pipelined restoring divider for the Q0.16 blend weight, two quotient bits per stage.
module fdpc_div
    import fdpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  pix_data_t   in_data,
    input  logic [15:0] num,
    input  logic [15:0] den,
    output logic        out_valid,
    output pix_data_t   out_data,
    output logic [15:0] quot
);

    logic        valid_reg [DIV_STAGES];
    pix_data_t   data_reg  [DIV_STAGES];
    logic [15:0] rem_reg   [DIV_STAGES];
    logic [15:0] den_reg   [DIV_STAGES];
    logic [15:0] q_reg     [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic        valid_in;
        pix_data_t   data_in;
        logic [15:0] rem_in, den_in, q_in;
        logic [16:0] t1, t2;
        logic        b1, b2;
        logic [15:0] r1, r2;

        if (s == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign data_in  = in_data;
            assign rem_in   = num;
            assign den_in   = den;
            assign q_in     = '0;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[s-1];
            assign data_in  = data_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign q_in     = q_reg[s-1];
        end

        // remainder stays below the divisor, so each trial fits 17 bits
        always_comb
        begin
            t1 = {rem_in, 1'b0};
            b1 = t1 >= {1'b0, den_in};
            r1 = b1 ? 16'(t1 - {1'b0, den_in}) : t1[15:0];
            t2 = {r1, 1'b0};
            b2 = t2 >= {1'b0, den_in};
            r2 = b2 ? 16'(t2 - {1'b0, den_in}) : t2[15:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            data_reg[s] <= data_in;
            rem_reg[s]  <= r2;
            den_reg[s]  <= den_in;
            q_reg[s]    <= {q_in[13:0], b1, b2};
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = data_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];

endmodule

// ----- rtl/fdpc_blend.sv -----
// Per-channel RGB565 blend and final pixel selection, two register stages.
module fdpc_blend
    import fdpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  pix_data_t   in_data,
    input  logic [15:0] weight,
    output logic        done,
    output logic [15:0] out_pixel
);

    logic [4:0]  ra, rb, ba, bb;
    logic [5:0]  ga, gb;
    logic [4:0]  rd, bd;
    logic [5:0]  gd;

    logic        va_reg;
    pix_data_t   data_a_reg;
    logic        rneg_reg, gneg_reg, bneg_reg;
    logic [20:0] rprod_reg, bprod_reg;
    logic [21:0] gprod_reg;

    logic [4:0]  r_mix, b_mix;
    logic [5:0]  g_mix;
    logic [15:0] pixel_next;

    logic        done_reg;
    logic [15:0] out_pixel_reg;

    // stage A: magnitude of each channel difference times the weight
    always_comb
    begin
        ra = in_data.art[15:11];
        ga = in_data.art[10:5];
        ba = in_data.art[4:0];
        rb = in_data.bg[15:11];
        gb = in_data.bg[10:5];
        bb = in_data.bg[4:0];
        rd = (rb >= ra) ? rb - ra : ra - rb;
        gd = (gb >= ga) ? gb - ga : ga - gb;
        bd = (bb >= ba) ? bb - ba : ba - bb;
    end

    // stage B: step from the artwork value toward the background value, then select by region
    always_comb
    begin
        r_mix = rneg_reg ? data_a_reg.art[15:11] - rprod_reg[20:16]
                         : data_a_reg.art[15:11] + rprod_reg[20:16];
        g_mix = gneg_reg ? data_a_reg.art[10:5] - gprod_reg[21:16]
                         : data_a_reg.art[10:5] + gprod_reg[21:16];
        b_mix = bneg_reg ? data_a_reg.art[4:0] - bprod_reg[20:16]
                         : data_a_reg.art[4:0] + bprod_reg[20:16];
        case (data_a_reg.region)
            REGION_BG:  pixel_next = data_a_reg.bg;
            REGION_ART: pixel_next = data_a_reg.art;
            default:    pixel_next = {r_mix, g_mix, b_mix};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= in_valid;
            done_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_a_reg    <= in_data;
        rneg_reg      <= rb < ra;
        gneg_reg      <= gb < ga;
        bneg_reg      <= bb < ba;
        rprod_reg     <= 21'(rd) * 21'(weight);
        gprod_reg     <= 22'(gd) * 22'(weight);
        bprod_reg     <= 21'(bd) * 21'(weight);
        out_pixel_reg <= pixel_next;
    end

    assign done      = done_reg;
    assign out_pixel = out_pixel_reg;

endmodule

// ----- rtl/feathered_disc_pixel_compositor.sv -----
// Top level of the feathered disc pixel compositor: config registers and pipeline.
// A render transaction, once accepted, passes the geometry/store stages, the divider
//   stages and the blend stages before its pixel shows with done high.
// Throughput: one transaction per cycle; busy stays low, the divider is fully pipelined.
// The receiver cannot stall; done and out_pixel are valid for exactly one cycle.
// Reset (rst_n low, asynchronous) clears all valid bits and restores the registers
//   to their defaults; frame stores keep their contents and need no clearing pass.
module feathered_disc_pixel_compositor
    import fdpc_pkg::*;
#(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [15:0] write_pixel,
    output logic        done,
    output logic [15:0] out_pixel,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers; every stage reads them live. The user must change them
    // only while the pipeline is empty; the block itself does not enforce this.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISC_CX: cfg_reg.disc_cx <= cfg_data[7:0];
                CFG_DISC_CY: cfg_reg.disc_cy <= cfg_data[7:0];
                CFG_REST_CX: cfg_reg.rest_cx <= cfg_data[7:0];
                CFG_REST_CY: cfg_reg.rest_cy <= cfg_data[7:0];
                CFG_INNER:   cfg_reg.inner   <= cfg_data;
                CFG_OUTER:   cfg_reg.outer   <= cfg_data;
                default:     ;  // drop writes to unmapped indexes
            endcase
        end
    end

    // Every cycle can take a transaction: the pipeline never backs up.
    logic busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= 1'b0;
    end

    assign busy = busy_reg;

    logic          accept;
    logic          wr_bg, wr_art;
    logic [AW-1:0] bg_addr, art_addr;
    logic [15:0]   wr_data;
    geom_res_t     geom_res;
    logic [15:0]   bg_pixel, art_pixel;

    assign accept = start && !busy_reg;

    // Geometry: clamp the position, form the squared distance and both store
    // addresses, then classify the pixel as background, disc or blend band.
    // Store writes leave from the same stage the reads do, so a write always
    // lands before any later render reads the store.
    fdpc_geom #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .mode        (mode),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .write_pixel (write_pixel),
        .cfg         (cfg_reg),
        .wr_bg       (wr_bg),
        .wr_art      (wr_art),
        .bg_addr     (bg_addr),
        .art_addr    (art_addr),
        .wr_data     (wr_data),
        .res         (geom_res)
    );

    // Frame stores; read data arrives aligned with the classification result.
    fdpc_store #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_store (
        .clk       (clk),
        .wr_bg     (wr_bg),
        .wr_art    (wr_art),
        .bg_addr   (bg_addr),
        .art_addr  (art_addr),
        .wr_data   (wr_data),
        .bg_pixel  (bg_pixel),
        .art_pixel (art_pixel)
    );

    // Blend weight: (d2 - inner) / (outer - inner) as Q0.16. Inside the band
    // the numerator is below the divisor, so 16 quotient bits are enough.
    pix_data_t   div_in_data, div_out_data;
    logic        div_out_valid;
    logic [15:0] weight;

    always_comb
    begin
        div_in_data.region = geom_res.region;
        div_in_data.art    = art_pixel;
        div_in_data.bg     = bg_pixel;
    end

    fdpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (geom_res.valid),
        .in_data   (div_in_data),
        .num       (geom_res.num),
        .den       (geom_res.den),
        .out_valid (div_out_valid),
        .out_data  (div_out_data),
        .quot      (weight)
    );

    // Channel blend and final selection into the output register.
    fdpc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_data   (div_out_data),
        .weight    (weight),
        .done      (done),
        .out_pixel (out_pixel)
    );

endmodule

// ----- rtl/fdpc_checker.sv -----
// Port-level checker for the compositor, bound to the top level.
module fdpc_checker
    import fdpc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] mode,
    input logic       done
);

    // The pipeline takes a transaction in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy asserted");

    // Every accepted render returns its pixel after the fixed latency.
    a_render_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == MODE_RENDER) |-> ##PIPE_LATENCY done)
        else $error("render transaction without result");

    // Writes and the unused mode produce no result.
    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode != MODE_RENDER) |-> ##PIPE_LATENCY !done)
        else $error("result from a non-render transaction");

    // No result appears without a matching render.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && mode == MODE_RENDER, PIPE_LATENCY))
        else $error("result without a render transaction");

endmodule

bind feathered_disc_pixel_compositor fdpc_checker u_fdpc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .mode  (mode),
    .done  (done)
);
